/* hdl/wall_column_texture_mapper_unit_defines.svh */
// Assertion macros shared by the mapper files.
`ifndef WALL_COLUMN_TEXTURE_MAPPER_UNIT_DEFINES_SVH
`define WALL_COLUMN_TEXTURE_MAPPER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WCM_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wcm check failed");

// Next-cycle implication, disabled during reset.
`define WCM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wcm check failed");

`endif

/* hdl/wcm_pkg.sv */
package wcm_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_PROJ_SCALE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXTURE_WIDTH  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXTURE_HEIGHT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OVERLAY_WIDTH  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_OVERLAY_HEIGHT = 3'd4;

   localparam logic [23:0] PROJ_SCALE_RESET     = 24'd141890;
   localparam logic [10:0] TEXTURE_WIDTH_RESET  = 11'd64;
   localparam logic [10:0] TEXTURE_HEIGHT_RESET = 11'd64;

   localparam logic [23:0] MIN_DIST = 24'd7;

   localparam logic [1:0] SIDE_NORTH = 2'd0;
   localparam logic [1:0] SIDE_SOUTH = 2'd1;
   localparam logic [1:0] SIDE_WEST  = 2'd2;
   localparam logic [1:0] SIDE_EAST  = 2'd3;

   typedef struct packed {
      logic [9:0]         column_x;
      logic [8:0]         row_y;
      logic [23:0]        perp_dist;
      logic [1:0]         wall_side;
      logic signed [31:0] hit_x;
      logic signed [31:0] hit_y;
   } req_type;

   typedef struct packed {
      logic       draw;
      logic [1:0] texture_select;
      logic [9:0] texel_x;
      logic [9:0] texel_y;
   } rsp_type;

   // Data riding along the height divider.
   typedef struct packed {
      logic [8:0] row_y;
      logic [1:0] wall_side;
      logic [9:0] texel_x;
      logic       covered;
   } side_a_type;

   // Data riding along the texture row dividers.
   typedef struct packed {
      logic       draw;
      logic [1:0] wall_side;
      logic [9:0] texel_x;
      logic       negative;
   } side_b_type;

endpackage

/* hdl/wall_column_texture_mapper_unit.sv */
// Wall column texture mapper. Takes one request per clock (busy is never
// raised) and returns exactly one result per request, in order, through the
// input register, a 48-cell divider for the wall height, a register,
// a 48-cell divider for the texture row remainder, a register with the
// texture height multiply, an 11-cell divider for the wrapped texture row,
// and the output register. The result sits on rsp_data for one cycle with
// rsp_strobe high; the receiver cannot stall it, so take it in that cycle.
// Write the csr_ registers only while no request is in flight.
`include "wall_column_texture_mapper_unit_defines.svh"

module wall_column_texture_mapper_unit #(
   parameter int SCREEN_WIDTH  = 640,
   parameter int SCREEN_HEIGHT = 480
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  wcm_pkg::req_type                  req_data,
   output logic                              rsp_strobe,
   output wcm_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [wcm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [wcm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int HQ_W  = 47;   // wall height, Q.16
   localparam int S_W   = 49;   // signed span math
   localparam int MAG_W = 48;
   localparam int CW    = 14;   // overlay compare
   localparam int SA_W  = $bits(wcm_pkg::side_a_type);
   localparam int SB_W  = $bits(wcm_pkg::side_b_type);

   localparam logic signed [S_W-1:0] H_S   = S_W'(SCREEN_HEIGHT);
   localparam logic signed [S_W-1:0] H_Q16 = S_W'(SCREEN_HEIGHT) << 16;

   // Configuration registers
   logic [23:0] proj_scale_ff;
   logic [10:0] texture_width_ff;
   logic [10:0] texture_height_ff;
   logic [9:0]  overlay_width_ff;
   logic [8:0]  overlay_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         proj_scale_ff     <= wcm_pkg::PROJ_SCALE_RESET;
         texture_width_ff  <= wcm_pkg::TEXTURE_WIDTH_RESET;
         texture_height_ff <= wcm_pkg::TEXTURE_HEIGHT_RESET;
         overlay_width_ff  <= '0;
         overlay_height_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            wcm_pkg::CSR_PROJ_SCALE:     proj_scale_ff     <= csr_wdata;
            wcm_pkg::CSR_TEXTURE_WIDTH:  texture_width_ff  <= csr_wdata[10:0];
            wcm_pkg::CSR_TEXTURE_HEIGHT: texture_height_ff <= csr_wdata[10:0];
            wcm_pkg::CSR_OVERLAY_WIDTH:  overlay_width_ff  <= csr_wdata[9:0];
            wcm_pkg::CSR_OVERLAY_HEIGHT: overlay_height_ff <= csr_wdata[8:0];
            default: ;   // drop writes to unmapped indexes
         endcase
      end
   end

   // Zero scale and texture size registers behave as one.
   logic [23:0] ps_eff;
   logic [10:0] tw_eff, th_eff;
   assign ps_eff = (proj_scale_ff == '0) ? 24'd1 : proj_scale_ff;
   assign tw_eff = (texture_width_ff == '0) ? 11'd1 : texture_width_ff;
   assign th_eff = (texture_height_ff == '0) ? 11'd1 : texture_height_ff;

   // The pipeline never stalls.
   assign busy = 1'b0;

   // ---------------------------------------------------------------
   // Stage A: clamp distance, texture column, overlay cover
   // ---------------------------------------------------------------
   logic [23:0]         clamp_dist;
   logic [15:0]         frac;
   logic [26:0]         tx_prod;
   logic [10:0]         tx_raw, tx_fin;
   logic signed [CW-1:0] row_s, col_s, row_lim, col_lim;
   wcm_pkg::side_a_type side_a;

   always_comb begin
      clamp_dist = (req_data.perp_dist < wcm_pkg::MIN_DIST) ? wcm_pkg::MIN_DIST
                                                            : req_data.perp_dist;
      frac    = (req_data.wall_side == wcm_pkg::SIDE_NORTH ||
                 req_data.wall_side == wcm_pkg::SIDE_SOUTH) ? req_data.hit_x[15:0]
                                                            : req_data.hit_y[15:0];
      tx_prod = 27'(frac) * 27'(tw_eff);
      tx_raw  = tx_prod[26:16];
      // Mirror the column on north and east faces.
      tx_fin  = (req_data.wall_side == wcm_pkg::SIDE_NORTH ||
                 req_data.wall_side == wcm_pkg::SIDE_EAST) ? (tw_eff - tx_raw - 11'd1)
                                                           : tx_raw;
      row_s   = $signed(CW'(req_data.row_y));
      col_s   = $signed(CW'(req_data.column_x));
      row_lim = $signed(CW'(SCREEN_HEIGHT)) - $signed(CW'(overlay_height_ff))
                + $signed(CW'(1));
      col_lim = $signed(CW'(SCREEN_WIDTH)) - $signed(CW'(overlay_width_ff));
      side_a.row_y     = req_data.row_y;
      side_a.wall_side = req_data.wall_side;
      side_a.texel_x   = tx_fin[9:0];
      side_a.covered   = (row_s >= row_lim) && (col_s > col_lim);
   end

   logic                a_valid_ff;
   logic [47:0]         a_num_ff;
   logic [23:0]         a_d_ff;
   wcm_pkg::side_a_type a_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      a_num_ff  <= {ps_eff, 24'd0};
      a_d_ff    <= clamp_dist;
      a_side_ff <= side_a;
   end

   // Height divider: hq = (proj_scale << 24) / dist
   logic            c1_valid;
   logic [47:0]     c1_quo;
   logic [SA_W-1:0] c1_side;

   wcm_div_chain #(.NW(48), .DW(24), .SW(SA_W)) u_height_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (a_valid_ff),
      .in_num   (a_num_ff),
      .in_rem   (24'd0),
      .in_d     (a_d_ff),
      .in_side  (a_side_ff),
      .out_valid(c1_valid),
      .out_quo  (c1_quo),
      .out_rem  (),
      .out_d    (),
      .out_side (c1_side)
   );

   // ---------------------------------------------------------------
   // Stage B: span, draw flag, texture row numerator
   // ---------------------------------------------------------------
   wcm_pkg::side_a_type  b_src;
   wcm_pkg::side_b_type  side_b;
   logic [HQ_W-1:0]      hq;
   logic signed [S_W-1:0] hqs, rows, top_q, bot_q, y0, y1r, y1, n17, mag;
   logic                 in_span;

   always_comb begin
      b_src   = c1_side;
      hq      = c1_quo[HQ_W-1:0];
      hqs     = $signed(S_W'(hq));
      rows    = $signed(S_W'(b_src.row_y));
      top_q   = H_Q16 - hqs;
      bot_q   = H_Q16 + hqs;
      y0      = (top_q > 0) ? (top_q >>> 17) : '0;
      y1r     = bot_q >>> 17;
      y1      = (y1r >= H_S) ? (H_S - 1) : y1r;
      in_span = (rows >= y0) && (rows < y1);
      n17     = (rows <<< 17) - H_Q16 + hqs;
      mag     = n17[S_W-1] ? -n17 : n17;
      side_b.draw      = in_span && !b_src.covered;
      side_b.wall_side = b_src.wall_side;
      side_b.texel_x   = b_src.texel_x;
      side_b.negative  = n17[S_W-1];
   end

   logic                b_valid_ff;
   logic [MAG_W-1:0]    b_num_ff;
   logic [MAG_W-1:0]    b_d_ff;
   wcm_pkg::side_b_type b_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= c1_valid;
      end
   end

   always_ff @(posedge clock) begin
      b_num_ff  <= mag[MAG_W-1:0];
      b_d_ff    <= {hq, 1'b0};
      b_side_ff <= side_b;
   end

   // Remainder divider: r = |n17| mod (2 hq)
   logic             c2_valid;
   logic [MAG_W-1:0] c2_rem, c2_d;
   logic [SB_W-1:0]  c2_side;

   wcm_div_chain #(.NW(MAG_W), .DW(MAG_W), .SW(SB_W)) u_rem_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (b_valid_ff),
      .in_num   (b_num_ff),
      .in_rem   ({MAG_W{1'b0}}),
      .in_d     (b_d_ff),
      .in_side  (b_side_ff),
      .out_valid(c2_valid),
      .out_quo  (),
      .out_rem  (c2_rem),
      .out_d    (c2_d),
      .out_side (c2_side)
   );

   // ---------------------------------------------------------------
   // Stage C: scale remainder by texture height
   // ---------------------------------------------------------------
   logic [MAG_W+10:0] prod_c;
   assign prod_c = (MAG_W + 11)'(c2_rem) * (MAG_W + 11)'(th_eff);

   logic             c_valid_ff;
   logic [MAG_W-1:0] c_rem_ff, c_d_ff;
   logic [10:0]      c_num_ff;
   logic [SB_W-1:0]  c_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= c2_valid;
      end
   end

   always_ff @(posedge clock) begin
      c_rem_ff  <= prod_c[MAG_W+10:11];
      c_num_ff  <= prod_c[10:0];
      c_d_ff    <= c2_d;
      c_side_ff <= c2_side;
   end

   // Row divider: m = r * th / (2 hq), always below th
   logic            c3_valid;
   logic [10:0]     c3_quo;
   logic [SB_W-1:0] c3_side;

   wcm_div_chain #(.NW(11), .DW(MAG_W), .SW(SB_W)) u_row_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (c_valid_ff),
      .in_num   (c_num_ff),
      .in_rem   (c_rem_ff),
      .in_d     (c_d_ff),
      .in_side  (c_side_ff),
      .out_valid(c3_valid),
      .out_quo  (c3_quo),
      .out_rem  (),
      .out_d    (),
      .out_side (c3_side)
   );

   // ---------------------------------------------------------------
   // Stage D: fold negative rows to the Euclidean remainder
   // ---------------------------------------------------------------
   wcm_pkg::side_b_type d_src;
   wcm_pkg::rsp_type    rsp_in;
   logic [10:0]         ty;

   always_comb begin
      d_src = c3_side;
      ty    = (d_src.negative && c3_quo != '0) ? (th_eff - c3_quo) : c3_quo;
      rsp_in.draw           = d_src.draw;
      rsp_in.texture_select = d_src.wall_side;
      rsp_in.texel_x        = d_src.texel_x;
      rsp_in.texel_y        = ty[9:0];
   end

   logic             rsp_strobe_ff;
   wcm_pkg::rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= c3_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   `WCM_ASSERT_IMPLIES(a_row_below_height, clock, reset, c3_valid, c3_quo < th_eff)
   `WCM_ASSERT_IMPLIES(a_divisor_nonzero, clock, reset, b_valid_ff, b_d_ff != '0)
   `WCM_ASSERT_IMPLIES(a_scaled_rem_fits, clock, reset, c_valid_ff, c_rem_ff < c_d_ff)

endmodule

/* hdl/wcm_div_cell.sv */
`include "wall_column_texture_mapper_unit_defines.svh"

module wcm_div_cell #(
   parameter int NW = 48,
   parameter int DW = 24,
   parameter int SW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_rem,
   input  logic [DW-1:0] in_d,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [NW-1:0] out_num,
   output logic [DW-1:0] out_rem,
   output logic [DW-1:0] out_d,
   output logic [SW-1:0] out_side
);

   logic          valid_ff;
   logic [NW-1:0] num_ff, num_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] d_ff;
   logic [SW-1:0] side_ff;
   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          ge;

   // Bring down the next numerator bit, subtract when it fits.
   always_comb begin
      trial  = {in_rem, in_num[NW-1]};
      diff   = trial - {1'b0, in_d};
      ge     = trial >= {1'b0, in_d};
      rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
      num_in = {in_num[NW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      d_ff    <= in_d;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_num   = num_ff;
   assign out_rem   = rem_ff;
   assign out_d     = d_ff;
   assign out_side  = side_ff;

   `WCM_ASSERT_IMPLIES(a_rem_below_divisor, clock, reset, valid_ff, rem_ff < d_ff)

endmodule

/* hdl/wcm_div_chain.sv */
module wcm_div_chain #(
   parameter int NW = 48,
   parameter int DW = 24,
   parameter int SW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_rem,
   input  logic [DW-1:0] in_d,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [NW-1:0] out_quo,
   output logic [DW-1:0] out_rem,
   output logic [DW-1:0] out_d,
   output logic [SW-1:0] out_side
);

   logic          v    [0:NW];
   logic [NW-1:0] num  [0:NW];
   logic [DW-1:0] rem  [0:NW];
   logic [DW-1:0] dv   [0:NW];
   logic [SW-1:0] side [0:NW];

   assign v[0]    = in_valid;
   assign num[0]  = in_num;
   assign rem[0]  = in_rem;
   assign dv[0]   = in_d;
   assign side[0] = in_side;

   // One quotient bit per cell, MSB first.
   for (genvar gi = 0; gi < NW; gi++) begin : g_cell
      wcm_div_cell #(.NW(NW), .DW(DW), .SW(SW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (v[gi]),
         .in_num   (num[gi]),
         .in_rem   (rem[gi]),
         .in_d     (dv[gi]),
         .in_side  (side[gi]),
         .out_valid(v[gi+1]),
         .out_num  (num[gi+1]),
         .out_rem  (rem[gi+1]),
         .out_d    (dv[gi+1]),
         .out_side (side[gi+1])
      );
   end

   assign out_valid = v[NW];
   assign out_quo   = num[NW];
   assign out_rem   = rem[NW];
   assign out_d     = dv[NW];
   assign out_side  = side[NW];

endmodule
